FILE: sv/bsm_pkg.sv
package bsm_pkg;

   // Item actions
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_PORT  = 2'd2;

   // I/O ports handled by the mapper
   localparam logic [7:0] PORT_CG_SWITCH = 8'h93;
   localparam logic [7:0] PORT_CG_SELECT = 8'hC1;
   localparam logic [7:0] PORT_KANJI     = 8'hC2;
   localparam logic [7:0] PORT_READ_LOW  = 8'hF0;
   localparam logic [7:0] PORT_READ_HIGH = 8'hF1;
   localparam logic [7:0] PORT_WRITE_EN  = 8'hF2;

   // Values on the character ROM switch port
   localparam logic [7:0] CG_ON_VALUE  = 8'h04;
   localparam logic [7:0] CG_OFF_VALUE = 8'h05;

   // Register indexes
   localparam logic [1:0] CSR_MODEL   = 2'd0;
   localparam logic [1:0] CSR_EXT_ROM = 2'd1;
   localparam logic [1:0] CSR_SYSROM2 = 2'd2;

   // Model codes with special behaviour
   localparam logic [2:0] MODEL_BASE  = 3'd0;
   localparam logic [2:0] MODEL_VOICE = 3'd3;

   // Source regions
   localparam logic [3:0] SRC_EMPTY  = 4'd0;
   localparam logic [3:0] SRC_BASIC  = 4'd1;
   localparam logic [3:0] SRC_KANJI  = 4'd2;
   localparam logic [3:0] SRC_VOICE  = 4'd3;
   localparam logic [3:0] SRC_EXT    = 4'd4;
   localparam logic [3:0] SRC_RAM    = 4'd5;
   localparam logic [3:0] SRC_CGA    = 4'd6;
   localparam logic [3:0] SRC_CGB    = 4'd7;
   localparam logic [3:0] SRC_SYSALT = 4'd8;

   // Slot kinds produced by the nibble code table
   localparam logic [3:0] KIND_EMPTY   = 4'd0;
   localparam logic [3:0] KIND_BASIC_L = 4'd1;
   localparam logic [3:0] KIND_BASIC_H = 4'd2;
   localparam logic [3:0] KIND_ALT_L   = 4'd3;
   localparam logic [3:0] KIND_ALT_H   = 4'd4;
   localparam logic [3:0] KIND_EXT_0   = 4'd5;
   localparam logic [3:0] KIND_EXT_1   = 4'd6;
   localparam logic [3:0] KIND_RAM_L   = 4'd7;
   localparam logic [3:0] KIND_RAM_H   = 4'd8;

   typedef struct packed {
      logic [3:0] src;
      logic [2:0] page;
   } entry_type;

   typedef struct packed {
      entry_type lo;
      entry_type hi;
   } pair_type;

   typedef struct packed {
      logic [2:0] model;
      logic       ext_present;
      logic       sysrom2_present;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [3:0]  region;
      logic [15:0] offset;
      logic        write_strobe;
      logic [7:0]  write_data;
   } rsp_type;

   function automatic entry_type make_entry(logic [3:0] src, logic [2:0] page);
      entry_type e;
      e.src  = src;
      e.page = page;
      return e;
   endfunction

   // Nibble code to slot kinds of the window pair, {first, second}
   function automatic logic [7:0] code_kinds(logic [3:0] code);
      logic [7:0] k;
      unique case (code)
         4'h1:    k = {KIND_BASIC_L, KIND_BASIC_H};
         4'h2:    k = {KIND_ALT_L,   KIND_ALT_H};
         4'h3:    k = {KIND_EXT_1,   KIND_EXT_1};
         4'h4:    k = {KIND_EXT_0,   KIND_EXT_0};
         4'h5:    k = {KIND_ALT_L,   KIND_BASIC_H};
         4'h6:    k = {KIND_BASIC_L, KIND_ALT_H};
         4'h7:    k = {KIND_EXT_0,   KIND_EXT_1};
         4'h8:    k = {KIND_EXT_1,   KIND_EXT_0};
         4'h9:    k = {KIND_EXT_1,   KIND_BASIC_H};
         4'hA:    k = {KIND_BASIC_L, KIND_EXT_1};
         4'hB:    k = {KIND_EXT_0,   KIND_ALT_H};
         4'hC:    k = {KIND_ALT_L,   KIND_EXT_0};
         4'hD:    k = {KIND_RAM_L,   KIND_RAM_H};
         default: k = {KIND_EMPTY,   KIND_EMPTY};
      endcase
      return k;
   endfunction

   function automatic entry_type slot_entry(logic [3:0] kind, logic [2:0] bbase,
                                            logic [3:0] alt, logic [2:0] abase,
                                            logic [2:0] rbase);
      entry_type e;
      unique case (kind)
         KIND_BASIC_L: e = make_entry(SRC_BASIC, bbase);
         KIND_BASIC_H: e = make_entry(SRC_BASIC, bbase + 3'd1);
         KIND_ALT_L:   e = make_entry(alt, abase);
         KIND_ALT_H:   e = make_entry(alt, abase + 3'd1);
         KIND_EXT_0:   e = make_entry(SRC_EXT, 3'd0);
         KIND_EXT_1:   e = make_entry(SRC_EXT, 3'd1);
         KIND_RAM_L:   e = make_entry(SRC_RAM, rbase);
         KIND_RAM_H:   e = make_entry(SRC_RAM, rbase + 3'd1);
         default:      e = make_entry(SRC_EMPTY, 3'd0);
      endcase
      return e;
   endfunction

   function automatic pair_type load_pair(logic [3:0] code, logic [2:0] bbase,
                                          logic [3:0] alt, logic [2:0] abase,
                                          logic [2:0] rbase);
      pair_type   p;
      logic [7:0] k;
      k    = code_kinds(code);
      p.lo = slot_entry(k[7:4], bbase, alt, abase, rbase);
      p.hi = slot_entry(k[3:0], bbase, alt, abase, rbase);
      return p;
   endfunction

endpackage

FILE: sv/bsm_ifs.sv
// Request channel: one CPU access or port write per beat
interface bsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output action, output address, output data, input ready);
   modport sink   (input valid, input action, input address, input data, output ready);
endinterface

// Response channel: one translated access per beat
interface bsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  region;
   logic [15:0] offset;
   logic        write_strobe;
   logic [7:0]  write_data;

   modport source (output valid, output region, output offset, output write_strobe,
                   output write_data, input ready);
   modport sink   (input valid, input region, input offset, input write_strobe,
                   input write_data, output ready);
endinterface

FILE: sv/bsm_map_core.sv
module bsm_map_core
   import bsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   entry_type  map_ff [8];
   entry_type  map_in [8];
   logic [3:0] we_ff, we_in;
   logic [7:0] low_set_ff, low_set_in;
   logic       kbank_ff, kbank_in;
   logic       cg_on_ff, cg_on_in;
   logic       cg_sel_ff, cg_sel_in;

   logic [7:0] port;
   logic       full;
   entry_type  cg_ent;

   // Shared F0 loader: windows 0..3 from a value, kanji bank and switch state
   logic [7:0] f0_val;
   logic       f0_kb;
   logic       f0_cg;
   entry_type  f0_win [4];
   pair_type   f0_lo, f0_hi;
   pair_type   f1_lo, f1_hi;

   assign port   = req.address[7:0];
   assign full   = (cfg.model != MODEL_BASE);
   assign cg_ent = make_entry(cg_sel_ff ? SRC_CGB : SRC_CGA, 3'd0);

   always_comb begin
      f0_lo = load_pair(f0_val[3:0], 3'd0, SRC_KANJI, {1'b0, f0_kb, 1'b0}, 3'd0);
      f0_hi = load_pair(f0_val[7:4], 3'd2, SRC_VOICE, 3'd0, 3'd2);
      f0_win[0] = f0_lo.lo;
      f0_win[1] = f0_lo.hi;
      f0_win[2] = f0_hi.lo;
      f0_win[3] = f0_hi.hi;
      if (f0_val[3:0] == 4'h6) begin
         f0_win[1] = make_entry(SRC_SYSALT, {1'b0, f0_kb, 1'b1});
      end
      if (f0_cg) begin
         f0_win[3] = cg_ent;
      end
   end

   // F1 always loads kanji as the alternate source
   always_comb begin
      f1_lo = load_pair(req.data[3:0], 3'd0, SRC_KANJI, {1'b0, kbank_ff, 1'b0}, 3'd4);
      f1_hi = load_pair(req.data[7:4], 3'd2, SRC_KANJI, {1'b0, kbank_ff, 1'b0}, 3'd6);
   end

   // Loader input selection per port
   always_comb begin
      f0_val = low_set_ff;
      f0_kb  = kbank_ff;
      f0_cg  = cg_on_ff;
      unique case (port)
         PORT_READ_LOW:  f0_val = req.data;
         PORT_KANJI:     f0_kb  = req.data[1];
         PORT_CG_SWITCH: f0_cg  = 1'b0;
         default: ;
      endcase
   end

   // State update on port beats
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         map_in[i] = map_ff[i];
      end
      we_in      = we_ff;
      low_set_in = low_set_ff;
      kbank_in   = kbank_ff;
      cg_on_in   = cg_on_ff;
      cg_sel_in  = cg_sel_ff;
      if (accept && req.action == ACT_PORT) begin
         unique case (port)
            PORT_CG_SWITCH: begin
               if (req.data == CG_ON_VALUE) begin
                  cg_on_in  = 1'b1;
                  map_in[3] = cg_ent;
               end else if (req.data == CG_OFF_VALUE) begin
                  cg_on_in = 1'b0;
                  for (int i = 0; i < 4; i++) map_in[i] = f0_win[i];
               end
            end
            PORT_CG_SELECT: cg_sel_in = ~req.data[1];
            PORT_KANJI: begin
               kbank_in = req.data[1];
               if (!req.data[0]) begin
                  // voice overlay where basic is absent; 0..1 voice model only
                  if (cfg.model == MODEL_VOICE) begin
                     if (map_ff[0] != make_entry(SRC_BASIC, 3'd0))
                        map_in[0] = make_entry(SRC_VOICE, 3'd0);
                     if (map_ff[1] != make_entry(SRC_BASIC, 3'd1))
                        map_in[1] = make_entry(SRC_VOICE, 3'd1);
                  end
                  if (map_ff[2] != make_entry(SRC_BASIC, 3'd2))
                     map_in[2] = make_entry(SRC_VOICE, 3'd0);
                  if (map_ff[3] != make_entry(SRC_BASIC, 3'd3))
                     map_in[3] = make_entry(SRC_VOICE, 3'd1);
               end else begin
                  for (int i = 0; i < 4; i++) map_in[i] = f0_win[i];
               end
            end
            PORT_READ_LOW: begin
               low_set_in = req.data;
               for (int i = 0; i < 4; i++) map_in[i] = f0_win[i];
            end
            PORT_READ_HIGH: begin
               map_in[4] = f1_lo.lo;
               map_in[5] = f1_lo.hi;
               map_in[6] = f1_hi.lo;
               map_in[7] = f1_hi.hi;
            end
            PORT_WRITE_EN: we_in = {req.data[6], req.data[4], req.data[2], req.data[0]};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff[0]  <= make_entry(SRC_BASIC, 3'd0);
         map_ff[1]  <= make_entry(SRC_BASIC, 3'd1);
         map_ff[2]  <= make_entry(SRC_EXT, 3'd0);
         map_ff[3]  <= make_entry(SRC_EXT, 3'd1);
         map_ff[4]  <= make_entry(SRC_RAM, 3'd4);
         map_ff[5]  <= make_entry(SRC_RAM, 3'd5);
         map_ff[6]  <= make_entry(SRC_RAM, 3'd6);
         map_ff[7]  <= make_entry(SRC_RAM, 3'd7);
         we_ff      <= 4'b1100;
         low_set_ff <= 8'h11;
         kbank_ff   <= 1'b0;
         cg_on_ff   <= 1'b0;
         cg_sel_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < 8; i++) map_ff[i] <= map_in[i];
         we_ff      <= we_in;
         low_set_ff <= low_set_in;
         kbank_ff   <= kbank_in;
         cg_on_ff   <= cg_on_in;
         cg_sel_ff  <= cg_sel_in;
      end
   end

   // Translation of the beat against the current map
   entry_type  sel;
   logic [3:0] src;
   logic [2:0] page;

   always_comb begin
      sel  = map_ff[req.address[15:13]];
      src  = sel.src;
      page = sel.page;
      if (src == SRC_SYSALT) begin
         if (cfg.sysrom2_present) page = 3'd0;
         else                     src  = SRC_KANJI;
      end
      if ((src == SRC_KANJI || src == SRC_VOICE || src == SRC_CGB) && !full)
         src = SRC_EMPTY;
      if (src == SRC_EXT && !cfg.ext_present)
         src = SRC_EMPTY;
      if (src == SRC_EMPTY || src == SRC_CGA || src == SRC_CGB || src > SRC_SYSALT)
         page = 3'd0;

      rsp = '0;
      unique case (req.action)
         ACT_READ: begin
            rsp.region = (src > SRC_SYSALT) ? SRC_EMPTY : src;
            rsp.offset = {page, req.address[12:0]};
         end
         ACT_WRITE: begin
            rsp.region       = SRC_RAM;
            rsp.offset       = req.address;
            rsp.write_strobe = we_ff[req.address[15:14]];
            rsp.write_data   = rsp.write_strobe ? req.data : 8'h00;
         end
         default: ;
      endcase
   end

endmodule

FILE: sv/bank_switch_memory_mapper.sv
// Bank mapper for the 64 KB CPU space: eight 8 KB read windows and four
// 16 KB write enables, loaded by writes to I/O ports.
//
// req_chan carries one beat per CPU access: a memory read, a memory write
// or a port write. rsp_chan returns exactly one beat for every request,
// in order: the target region, the offset inside it and, for writes, the
// RAM strobe and data. Port writes return an all-zero beat.
// The core translates combinationally and registers map updates; the
// response is registered; one request per cycle is taken unless stalled.
// A second output stage holds one extra response, so a request is still
// taken in the cycle the receiver first stalls; while both stages are
// full, req_chan.ready is low. A port write takes effect on the very next
// request.
// csr_we/csr_index/csr_wdata set model, extension ROM and second system ROM
// presence; write them only while no requests are in flight.
// Reset is synchronous: it restores the power-on window map and write
// enables, clears the configuration and empties both output stages.
module bank_switch_memory_mapper
   import bsm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bsm_req_if.sink    req_chan,
   bsm_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_wdata
);

   cfg_type cfg_ff;
   req_type req;
   rsp_type result;
   logic    accept;
   logic    pop;

   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   assign req.action  = req_chan.action;
   assign req.address = req_chan.address;
   assign req.data    = req_chan.data;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODEL:   cfg_ff.model           <= csr_wdata;
            CSR_EXT_ROM: cfg_ff.ext_present     <= csr_wdata[0];
            CSR_SYSROM2: cfg_ff.sysrom2_present <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   bsm_map_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .cfg    (cfg_ff),
      .rsp    (result)
   );

   // Output register plus skid stage
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.region       = out_ff.region;
   assign rsp_chan.offset       = out_ff.offset;
   assign rsp_chan.write_strobe = out_ff.write_strobe;
   assign rsp_chan.write_data   = out_ff.write_data;

   // Skid stage only fills behind a full output register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   // Every accepted beat leaves a response waiting
   assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted beat produced no response");

   // Draining the output register promotes the skid beat
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && out_ff == $past(skid_ff))
      else $error("skid beat lost on drain");

   // A stall with a full output register parks the new beat in the skid stage
   assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && !rsp_chan.ready |=> skid_valid_ff)
      else $error("beat accepted under stall not held");

endmodule
